[rtl/core/tisd_pkg.sv]
// Package for the TGA image stream decoder: parser phases, result kinds,
// error codes and header byte positions.
// No dependencies; tga_image_stream_decoder_core.sv uses it.
package tisd_pkg;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_SKIP   = 3'd1,
      PH_PACKET = 3'd2,
      PH_PIXEL  = 3'd3,
      PH_DONE   = 3'd4
   } phase_type;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_DEPTH   = 2'd1;
   localparam logic [1:0] ERR_OVERRUN = 2'd2;

   localparam logic [4:0] HDR_ID_LEN   = 5'd0;
   localparam logic [4:0] HDR_TYPE     = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_DEPTH    = 5'd16;

   localparam logic [7:0] DEPTH_16 = 8'd16;
   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;

   localparam logic [7:0] RLE_TYPE_RESET = 8'd10;
   localparam logic [7:0] RUN_BIAS       = 8'd127;
   localparam logic [7:0] RUN_MAX        = 8'd128;

endpackage

[rtl/core/tisd_stream_if.sv]
// Valid/ready channel interfaces for the TGA image stream decoder: the byte
// input channel and the result channel.
// Depends on nothing but the signals it bundles.
interface tisd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       start_of_file;

   modport source (output valid, output file_byte, output start_of_file, input ready);
   modport sink   (input valid, input file_byte, input start_of_file, output ready);
endinterface

interface tisd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  alpha;
   logic        has_alpha;
   logic [7:0]  run_length;
   logic [15:0] image_width;
   logic [15:0] image_height;
   logic        last;
   logic [1:0]  fault_code;

   modport source (output valid, output kind, output red, output green, output blue,
                   output alpha, output has_alpha, output run_length, output image_width,
                   output image_height, output last, output fault_code, input ready);
   modport sink   (input valid, input kind, input red, input green, input blue,
                   input alpha, input has_alpha, input run_length, input image_width,
                   input image_height, input last, input fault_code, output ready);
endinterface

[rtl/core/tga_image_stream_decoder_core.sv]
// Top level of the TGA image stream decoder: header parser, RLE packet
// decoder and pixel assembler with a registered result stage.
// Depends on tisd_pkg and the channel interfaces in tisd_stream_if.sv.
//
// The req_chan channel carries one file byte per transaction; start_of_file
// marks header byte 0 of a new file and restarts the parser. The rsp_chan
// channel carries header, pixel run and error results. The csr port writes
// the image type code that selects run-length decoding; it is sampled when a
// header completes.
// A byte that completes a result makes that result valid on rsp_chan in the
// next cycle. The throughput is one byte per cycle, set by the single result
// register, as long as no result waits with rsp_chan.ready low.
// While a result waits and the receiver holds ready low, req_chan.ready is
// low; as soon as the result is taken, or in the same cycle it is taken, the
// next byte is accepted.
// Reset returns the image type register to 10, clears the parser to the
// header phase and drops rsp_chan.valid.
module tga_image_stream_decoder_core (
   input  logic           clock,
   input  logic           reset,
   tisd_req_if.sink       req_chan,
   tisd_rsp_if.source     rsp_chan,
   input  logic           csr_wr_en,
   input  logic [7:0]     csr_wr_data
);

   tisd_pkg::phase_type phase_ff, phase_in, ph;
   logic [4:0]  hcnt_ff, hcnt_in, hcnt;
   logic [7:0]  id_len_ff, id_len_in, id_len;
   logic [7:0]  type_ff, type_in, img_type;
   logic [15:0] width_ff, width_in, width;
   logic [15:0] height_ff, height_in, height;
   logic [7:0]  depth_ff, depth_in, depth;
   logic [8:0]  skip_ff, skip_in, skip;
   logic [7:0]  pkt_rem_ff, pkt_rem_in, pkt_rem;
   logic        pkt_run_ff, pkt_run_in, pkt_run;
   logic [31:0] pix_ff, pix_in, pix;
   logic [1:0]  idx_ff, idx_in, idx;
   logic [31:0] left_ff, left_in, left;
   logic        rle_ff, rle_in, rle;
   logic [7:0]  rle_type_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  red_ff, red_in, green_ff, green_in, blue_ff, blue_in, alpha_ff, alpha_in;
   logic        has_alpha_ff, has_alpha_in;
   logic [7:0]  run_ff, run_in;
   logic [15:0] owidth_ff, owidth_in, oheight_ff, oheight_in;
   logic        last_ff, last_in;
   logic [1:0]  err_ff, err_in;
   logic        emit;

   logic        accept, sof;
   logic [7:0]  b;
   logic [8:0]  skip_dec;
   logic        rle_now, depth_ok;
   logic [31:0] area;
   logic [2:0]  bpp;
   logic [31:0] word;
   logic        pix_done;
   logic [31:0] run_full, left_dec, left_run;
   logic [7:0]  rem_dec;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign sof    = req_chan.start_of_file;
   assign b      = req_chan.file_byte;

   assign ph      = sof ? tisd_pkg::PH_HEADER : phase_ff;
   assign hcnt    = sof ? 5'd0 : hcnt_ff;
   assign id_len  = sof ? 8'd0 : id_len_ff;
   assign img_type = sof ? 8'd0 : type_ff;
   assign width   = sof ? 16'd0 : width_ff;
   assign height  = sof ? 16'd0 : height_ff;
   assign depth   = sof ? 8'd0 : depth_ff;
   assign skip    = sof ? 9'd0 : skip_ff;
   assign pkt_rem = sof ? 8'd0 : pkt_rem_ff;
   assign pkt_run = sof ? 1'b0 : pkt_run_ff;
   assign pix     = sof ? 32'd0 : pix_ff;
   assign idx     = sof ? 2'd0 : idx_ff;
   assign left    = sof ? 32'd0 : left_ff;
   assign rle     = sof ? 1'b0 : rle_ff;

   assign skip_dec = skip - 9'd1;
   assign rle_now  = (img_type == rle_type_ff);
   assign depth_ok = (depth == tisd_pkg::DEPTH_24) || (depth == tisd_pkg::DEPTH_32) ||
                     (!rle_now && (depth == tisd_pkg::DEPTH_16));
   assign area     = 32'(width) * 32'(height);
   assign bpp      = (depth == tisd_pkg::DEPTH_16) ? 3'd2 :
                     (depth == tisd_pkg::DEPTH_24) ? 3'd3 : 3'd4;
   assign word     = pix | (32'(b) << {idx, 3'b000});
   assign pix_done = ({1'b0, idx} + 3'd1) >= bpp;
   assign run_full = {24'd0, pkt_rem};
   assign left_dec = left - 32'd1;
   assign rem_dec  = (pkt_rem != 8'd0) ? (pkt_rem - 8'd1) : 8'd0;

   always_comb begin
      phase_in  = ph;
      hcnt_in   = hcnt;
      id_len_in = id_len;
      type_in   = img_type;
      width_in  = width;
      height_in = height;
      depth_in  = depth;
      skip_in   = skip;
      pkt_rem_in = pkt_rem;
      pkt_run_in = pkt_run;
      pix_in    = pix;
      idx_in    = idx;
      left_in   = left;
      rle_in    = rle;
      left_run  = 32'd0;
      emit         = 1'b0;
      kind_in      = tisd_pkg::KIND_HEADER;
      red_in       = 8'd0;
      green_in     = 8'd0;
      blue_in      = 8'd0;
      alpha_in     = 8'd0;
      has_alpha_in = 1'b0;
      run_in       = 8'd0;
      owidth_in    = 16'd0;
      oheight_in   = 16'd0;
      last_in      = 1'b0;
      err_in       = tisd_pkg::ERR_NONE;

      unique case (ph)
         tisd_pkg::PH_HEADER: begin
            case (hcnt)
               tisd_pkg::HDR_ID_LEN:    id_len_in = b;
               tisd_pkg::HDR_TYPE:      type_in = b;
               tisd_pkg::HDR_WIDTH_LO:  width_in = {width[15:8], b};
               tisd_pkg::HDR_WIDTH_HI:  width_in = {b, width[7:0]};
               tisd_pkg::HDR_HEIGHT_LO: height_in = {height[15:8], b};
               tisd_pkg::HDR_HEIGHT_HI: height_in = {b, height[7:0]};
               tisd_pkg::HDR_DEPTH: begin
                  depth_in = b;
                  skip_in  = {1'b0, id_len} + 9'd1;
                  phase_in = tisd_pkg::PH_SKIP;
               end
               default: ;
            endcase
            hcnt_in = hcnt + 5'd1;
         end
         tisd_pkg::PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == 9'd0) begin
               rle_in = rle_now;
               emit   = 1'b1;
               if (!depth_ok) begin
                  kind_in  = tisd_pkg::KIND_ERROR;
                  last_in  = 1'b1;
                  err_in   = tisd_pkg::ERR_DEPTH;
                  phase_in = tisd_pkg::PH_DONE;
               end else begin
                  left_in      = area;
                  pix_in       = 32'd0;
                  idx_in       = 2'd0;
                  pkt_rem_in   = 8'd0;
                  pkt_run_in   = 1'b0;
                  has_alpha_in = (depth == tisd_pkg::DEPTH_32);
                  owidth_in    = width;
                  oheight_in   = height;
                  last_in      = (width == 16'd0) || (height == 16'd0);
                  if ((width == 16'd0) || (height == 16'd0)) begin
                     phase_in = tisd_pkg::PH_DONE;
                  end else begin
                     phase_in = rle_now ? tisd_pkg::PH_PACKET : tisd_pkg::PH_PIXEL;
                  end
               end
            end
         end
         tisd_pkg::PH_PACKET: begin
            pkt_run_in = b[7];
            pkt_rem_in = b[7] ? (b - tisd_pkg::RUN_BIAS) : (b + 8'd1);
            pix_in     = 32'd0;
            idx_in     = 2'd0;
            phase_in   = tisd_pkg::PH_PIXEL;
         end
         tisd_pkg::PH_PIXEL: begin
            if (!pix_done) begin
               pix_in = word;
               idx_in = idx + 2'd1;
            end else begin
               pix_in = 32'd0;
               idx_in = 2'd0;
               if (left == 32'd0) begin
                  phase_in = tisd_pkg::PH_DONE;
               end else begin
                  emit = 1'b1;
                  kind_in = tisd_pkg::KIND_PIXEL;
                  if (depth == tisd_pkg::DEPTH_16) begin
                     blue_in  = {word[4:0], 3'b000};
                     green_in = {word[9:5], 3'b000};
                     red_in   = {word[14:10], 3'b000};
                  end else begin
                     blue_in  = word[7:0];
                     green_in = word[15:8];
                     red_in   = word[23:16];
                     alpha_in = (depth == tisd_pkg::DEPTH_32) ? word[31:24] : 8'd0;
                  end
                  has_alpha_in = (depth == tisd_pkg::DEPTH_32);
                  if (rle && pkt_run) begin
                     if (run_full > left) begin
                        run_in   = left[7:0];
                        err_in   = tisd_pkg::ERR_OVERRUN;
                        left_run = 32'd0;
                     end else begin
                        run_in   = pkt_rem;
                        left_run = left - run_full;
                     end
                     left_in    = left_run;
                     pkt_rem_in = 8'd0;
                  end else begin
                     run_in   = 8'd1;
                     left_run = left_dec;
                     left_in  = left_dec;
                     if (rle) begin
                        pkt_rem_in = rem_dec;
                        if ((left_dec == 32'd0) && (rem_dec != 8'd0)) begin
                           err_in = tisd_pkg::ERR_OVERRUN;
                        end
                     end
                  end
                  last_in = (left_run == 32'd0);
                  if (left_run == 32'd0) begin
                     phase_in = tisd_pkg::PH_DONE;
                  end else if (rle && (pkt_rem_in == 8'd0)) begin
                     phase_in = tisd_pkg::PH_PACKET;
                  end else begin
                     phase_in = tisd_pkg::PH_PIXEL;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = accept ? emit : (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rle_type_ff <= tisd_pkg::RLE_TYPE_RESET;
      end else if (csr_wr_en) begin
         rle_type_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= tisd_pkg::PH_HEADER;
         hcnt_ff    <= 5'd0;
         id_len_ff  <= 8'd0;
         type_ff    <= 8'd0;
         width_ff   <= 16'd0;
         height_ff  <= 16'd0;
         depth_ff   <= 8'd0;
         skip_ff    <= 9'd0;
         pkt_rem_ff <= 8'd0;
         pkt_run_ff <= 1'b0;
         pix_ff     <= 32'd0;
         idx_ff     <= 2'd0;
         left_ff    <= 32'd0;
         rle_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         hcnt_ff    <= hcnt_in;
         id_len_ff  <= id_len_in;
         type_ff    <= type_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         depth_ff   <= depth_in;
         skip_ff    <= skip_in;
         pkt_rem_ff <= pkt_rem_in;
         pkt_run_ff <= pkt_run_in;
         pix_ff     <= pix_in;
         idx_ff     <= idx_in;
         left_ff    <= left_in;
         rle_ff     <= rle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         kind_ff      <= kind_in;
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         alpha_ff     <= alpha_in;
         has_alpha_ff <= has_alpha_in;
         run_ff       <= run_in;
         owidth_ff    <= owidth_in;
         oheight_ff   <= oheight_in;
         last_ff      <= last_in;
         err_ff       <= err_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = kind_ff;
   assign rsp_chan.red          = red_ff;
   assign rsp_chan.green        = green_ff;
   assign rsp_chan.blue         = blue_ff;
   assign rsp_chan.alpha        = alpha_ff;
   assign rsp_chan.has_alpha    = has_alpha_ff;
   assign rsp_chan.run_length   = run_ff;
   assign rsp_chan.image_width  = owidth_ff;
   assign rsp_chan.image_height = oheight_ff;
   assign rsp_chan.last         = last_ff;
   assign rsp_chan.fault_code   = err_ff;

`ifndef NO_ASSERTIONS
   // The pixel phase is only entered with pixels still to deliver.
   a_pixel_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == tisd_pkg::PH_PIXEL) |-> (left_ff != 32'd0))
      else $error("pixel phase with no pixels left");

   // The skip counter never sits at zero while skipping.
   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == tisd_pkg::PH_SKIP) |-> (skip_ff != 9'd0))
      else $error("skip phase with empty skip count");

   // A packet never holds more than 128 pixels.
   a_packet_bound: assert property (@(posedge clock) disable iff (reset)
      pkt_rem_ff <= tisd_pkg::RUN_MAX)
      else $error("packet count out of range");

   // Every pixel result covers at least one pixel.
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (kind_ff == tisd_pkg::KIND_PIXEL)) |-> (run_ff != 8'd0))
      else $error("pixel result with zero run length");

   // A stalled result blocks the input so no result can be overwritten.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input accepted while a result is stalled");
`endif

endmodule
